// ===== src/uvs_pkg.sv =====
`timescale 1ns / 1ps
package uvs_pkg;

  // Grid and arithmetic sizes.
  localparam int MaxSegments = 1024;
  localparam int CordicSteps = 16;
  localparam int SegW        = 11;
  localparam int IdxW        = 21;
  localparam int TexW        = 17;
  localparam int PosW        = 16;
  localparam int AngW        = 36;
  localparam int CorW        = 34;
  localparam int DivBits     = 27;
  localparam int DivW        = 12;

  // Register addresses, one word apart.
  localparam logic [2:0] AddrSegU = 3'd0;
  localparam logic [2:0] AddrSegV = 3'd4;

  localparam logic signed [AngW-1:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [AngW-1:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [CorW-1:0] GainQ30   = 34'sd652032874;

  // Queue depth between front and back.
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;

  // Arctangent table in Q2.30.
  function automatic logic signed [AngW-1:0] atan_q30(input int k);
    logic signed [AngW-1:0] r;
    begin
      case (k)
        0: r = 36'sd843314857;
        1: r = 36'sd497837829;
        2: r = 36'sd263043837;
        3: r = 36'sd133525159;
        4: r = 36'sd67021687;
        5: r = 36'sd33543516;
        6: r = 36'sd16775851;
        7: r = 36'sd8388437;
        8: r = 36'sd4194283;
        9: r = 36'sd2097149;
        default: r = AngW'(64'sd1 <<< (30 - k));
      endcase
      return r;
    end
  endfunction

  // One classified grid point as carried from front to back.
  typedef struct packed {
    logic [SegW-1:0] col;
    logic [SegW-1:0] row;
    logic [SegW-1:0] nu;
    logic [SegW-1:0] nv;
    logic            face;
  } item_t;

endpackage

// ===== src/uvs_front.sv =====
`timescale 1ns / 1ps
module uvs_front
  import uvs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [SegW-1:0] column_index,
  input  logic [SegW-1:0] row_index,
  input  logic [SegW-1:0] seg_u,
  input  logic [SegW-1:0] seg_v,
  input  logic            pop,
  output logic            busy,
  output logic            q_valid,
  output item_t           q_item
);

  item_t                 mem [QDepth];
  logic [QPtrW-1:0]      wptr;
  logic [QPtrW-1:0]      rptr;
  logic [QPtrW:0]        count;
  logic [SegW-1:0]       nu;
  logic [SegW-1:0]       nv;
  logic [SegW-1:0]       col;
  logic [SegW-1:0]       row;
  item_t                 cls;
  logic                  push;

  // Effective counts and clamped grid point.
  always_comb begin
    nu = (seg_u == '0) ? SegW'(1) : ((seg_u > SegW'(MaxSegments)) ? SegW'(MaxSegments) : seg_u);
    nv = (seg_v == '0) ? SegW'(1) : ((seg_v > SegW'(MaxSegments)) ? SegW'(MaxSegments) : seg_v);
    col = (column_index > nu) ? nu : column_index;
    row = (row_index > nv) ? nv : row_index;
    cls.col = col;
    cls.row = row;
    cls.nu = nu;
    cls.nv = nv;
    cls.face = (col < nu) && (row < nv);
  end

  assign busy    = (count == (QPtrW+1)'(QDepth));
  assign push    = start && !busy;
  assign q_valid = (count != '0);
  assign q_item  = mem[rptr];

  // Small word queue toward the back part.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= cls;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    end
  end

endmodule

// ===== src/uvs_div.sv =====
`timescale 1ns / 1ps
module uvs_div
  import uvs_pkg::*;
(
  input  logic               clk,
  input  logic [DivBits-1:0] num,
  input  logic [SegW-1:0]    den,
  output logic [TexW-1:0]    quo
);

  // One quotient bit per stage, restoring.
  logic [DivW-1:0]    rem [DivBits+1];
  logic [DivBits-1:0] nm  [DivBits+1];
  logic [DivBits-1:0] q   [DivBits+1];
  logic [SegW-1:0]    d   [DivBits+1];

  always_comb begin
    rem[0] = '0;
    nm[0]  = num;
    q[0]   = '0;
    d[0]   = den;
  end

  for (genvar i = 0; i < DivBits; i++) begin : g_st
    logic [DivW:0] tr;
    logic          ge;
    always_comb begin
      tr = {rem[i], nm[i][DivBits-1-i]};
      ge = (tr >= {2'b00, d[i]});
    end
    always_ff @(posedge clk) begin
      rem[i+1] <= ge ? DivW'(tr - {2'b00, d[i]}) : DivW'(tr);
      q[i+1]   <= {q[i][DivBits-2:0], ge};
      nm[i+1]  <= nm[i];
      d[i+1]   <= d[i];
    end
  end

  assign quo = q[DivBits][TexW-1:0];

endmodule

// ===== src/uvs_cordic.sv =====
`timescale 1ns / 1ps
module uvs_cordic
  import uvs_pkg::*;
(
  input  logic                   clk,
  input  logic signed [AngW-1:0] ang,
  output logic signed [CorW-1:0] cos_o,
  output logic signed [CorW-1:0] sin_o
);

  logic signed [CorW-1:0] x [CordicSteps+1];
  logic signed [CorW-1:0] y [CordicSteps+1];
  logic signed [AngW-1:0] z [CordicSteps+1];
  logic                   f [CordicSteps+1];

  // Quadrant fold into [-pi/2, pi/2], registered.
  always_ff @(posedge clk) begin
    x[0] <= GainQ30;
    y[0] <= '0;
    if (ang > HalfPiQ30) begin
      z[0] <= ang - PiQ30;
      f[0] <= 1'b1;
    end else if (ang < -HalfPiQ30) begin
      z[0] <= ang + PiQ30;
      f[0] <= 1'b1;
    end else begin
      z[0] <= ang;
      f[0] <= 1'b0;
    end
  end

  // One rotation per stage.
  for (genvar k = 0; k < CordicSteps; k++) begin : g_rot
    always_ff @(posedge clk) begin
      f[k+1] <= f[k];
      if (!z[k][AngW-1]) begin
        x[k+1] <= x[k] - (y[k] >>> k);
        y[k+1] <= y[k] + (x[k] >>> k);
        z[k+1] <= z[k] - atan_q30(k);
      end else begin
        x[k+1] <= x[k] + (y[k] >>> k);
        y[k+1] <= y[k] - (x[k] >>> k);
        z[k+1] <= z[k] + atan_q30(k);
      end
    end
  end

  assign cos_o = f[CordicSteps] ? -x[CordicSteps] : x[CordicSteps];
  assign sin_o = f[CordicSteps] ? -y[CordicSteps] : y[CordicSteps];

endmodule

// ===== src/uvs_back.sv =====
`timescale 1ns / 1ps
module uvs_back
  import uvs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  item_t                  in_item,
  output logic                   done,
  output logic [IdxW-1:0]        vertex_index,
  output logic signed [PosW-1:0] pos_x,
  output logic signed [PosW-1:0] pos_y,
  output logic signed [PosW-1:0] pos_z,
  output logic [TexW-1:0]        tex_u,
  output logic [TexW-1:0]        tex_v,
  output logic                   face_valid,
  output logic [IdxW-1:0]        corner_a,
  output logic [IdxW-1:0]        corner_b,
  output logic [IdxW-1:0]        corner_c,
  output logic [IdxW-1:0]        corner_d
);

  // Stage timing: 1 entry, DivBits divide, 1 angle multiply, 1 angle scale,
  // CordicSteps+1 rotation, 2 product, 1 output.
  localparam int LatDiv = DivBits + 1;
  localparam int LatAng = 2;
  localparam int LatCor = CordicSteps + 1;
  localparam int LatMul = 2;
  localparam int Lat    = LatDiv + LatAng + LatCor + LatMul;

  logic [Lat-1:0]   vld;
  item_t            it0;
  logic [IdxW-1:0]  idx0;
  logic [IdxW-1:0]  idx_d [Lat-1];
  item_t            it_d  [Lat-1];
  logic [TexW-1:0]  tu_q, tv_q;
  logic [TexW-1:0]  tu_d [LatAng+LatCor+LatMul];
  logic [TexW-1:0]  tv_d [LatAng+LatCor+LatMul];
  logic signed [AngW+18:0] pu, pv;
  logic signed [AngW-1:0]  au, av;
  logic signed [CorW-1:0]  cu, su, cv, sv;
  logic signed [2*CorW-1:0] mx, my;
  logic signed [CorW-1:0]  sv_q;
  logic signed [2*CorW-1:0] rx, ry;
  logic signed [CorW-1:0]  rz;

  // Entry register: index product.
  always_ff @(posedge clk) begin
    it0  <= in_item;
    idx0 <= IdxW'(in_item.col * (in_item.nv + 1'b1) + in_item.row);
    if (rst) vld <= '0;
    else vld <= {vld[Lat-2:0], in_valid};
  end

  uvs_div u_du (.clk(clk), .num({it0.col, 16'd0}), .den(it0.nu), .quo(tu_q));
  uvs_div u_dv (.clk(clk), .num({it0.row, 16'd0}), .den(it0.nv), .quo(tv_q));

  // Delay line for side fields.
  always_ff @(posedge clk) begin
    idx_d[0] <= idx0;
    it_d[0]  <= it0;
    for (int i = 1; i < Lat-1; i++) begin
      idx_d[i] <= idx_d[i-1];
      it_d[i]  <= it_d[i-1];
    end
    tu_d[0] <= tu_q;
    tv_d[0] <= tv_q;
    for (int i = 1; i < LatAng+LatCor+LatMul; i++) begin
      tu_d[i] <= tu_d[i-1];
      tv_d[i] <= tv_d[i-1];
    end
  end

  // Angle: product by pi, then scale with truncation toward zero.
  always_ff @(posedge clk) begin
    pu <= (AngW+19)'($signed({1'b0, tu_q}) - 18'sd32768) * PiQ30;
    pv <= (AngW+19)'($signed({1'b0, tv_q}) - 18'sd32768) * PiQ30;
    au <= AngW'((pu + (pu[AngW+18] ? (AngW+19)'(32767) : '0)) >>> 15);
    av <= AngW'((pv + (pv[AngW+18] ? (AngW+19)'(65535) : '0)) >>> 16);
  end

  uvs_cordic u_cu (.clk(clk), .ang(au), .cos_o(cu), .sin_o(su));
  uvs_cordic u_cv (.clk(clk), .ang(av), .cos_o(cv), .sin_o(sv));

  // Products, then rounding and saturation.
  function automatic logic signed [PosW-1:0] sat(input logic signed [2*CorW-1:0] v);
    begin
      if (v > 32767) sat = 16'sd32767;
      else if (v < -32768) sat = -16'sd32768;
      else sat = PosW'(v);
    end
  endfunction

  always_ff @(posedge clk) begin
    mx   <= cu * cv;
    my   <= su * cv;
    sv_q <= sv;
    rx   <= (mx + (2*CorW)'(64'sd1 <<< 44)) >>> 45;
    ry   <= (my + (2*CorW)'(64'sd1 <<< 44)) >>> 45;
    rz   <= (sv_q + CorW'(64'sd1 <<< 14)) >>> 15;
  end

  // Output word register, shown for one cycle.
  always_ff @(posedge clk) begin
    vertex_index <= idx_d[Lat-2];
    pos_x <= sat(rx);
    pos_y <= sat(ry);
    pos_z <= sat((2*CorW)'(rz));
    tex_u <= tu_d[LatAng+LatCor+LatMul-1];
    tex_v <= tv_d[LatAng+LatCor+LatMul-1];
    face_valid <= it_d[Lat-2].face;
    corner_a <= it_d[Lat-2].face ? idx_d[Lat-2] : '0;
    corner_b <= it_d[Lat-2].face ? idx_d[Lat-2] + 1'b1 : '0;
    corner_c <= it_d[Lat-2].face ? IdxW'(idx_d[Lat-2] + it_d[Lat-2].nv + 2'd2) : '0;
    corner_d <= it_d[Lat-2].face ? IdxW'(idx_d[Lat-2] + it_d[Lat-2].nv + 1'b1) : '0;
    if (rst) done <= 1'b0;
    else done <= vld[Lat-1];
  end

endmodule

// ===== src/uv_sphere_vertex_generator_core.sv =====
`timescale 1ns / 1ps
// UV-sphere vertex generator.
// Command channel: a grid word (column_index, row_index) is taken at a rising
// edge with start high and busy low. One result word follows per command,
// shown for exactly one cycle with done high; it cannot be held off.
// The path from acceptance to done runs through the 27-stage texture
// divider, the angle multiply, the 17-stage CORDIC pipeline and the product
// stages. One command is taken every cycle; busy only rises if the
// four-entry queue between classifier and pipeline fills, which the back end,
// draining every cycle, never lets happen.
// Configuration: APB registers segments_u at 0x0 and segments_v at 0x4
// (11 bits each), to be written only while idle (not enforced). Reads return
// the stored value. Reset clears queue and pipeline and sets both counts to 16.
module uv_sphere_vertex_generator_core
  import uvs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   start,
  output logic                   busy,
  input  logic [SegW-1:0]        column_index,
  input  logic [SegW-1:0]        row_index,
  output logic                   done,
  output logic [IdxW-1:0]        vertex_index,
  output logic signed [PosW-1:0] pos_x,
  output logic signed [PosW-1:0] pos_y,
  output logic signed [PosW-1:0] pos_z,
  output logic [TexW-1:0]        tex_u,
  output logic [TexW-1:0]        tex_v,
  output logic                   face_valid,
  output logic [IdxW-1:0]        corner_a,
  output logic [IdxW-1:0]        corner_b,
  output logic [IdxW-1:0]        corner_c,
  output logic [IdxW-1:0]        corner_d
);

  logic [SegW-1:0] segments_u;
  logic [SegW-1:0] segments_v;
  logic            q_valid;
  item_t           q_item;

  assign pready = 1'b1;

  // Register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      segments_u <= SegW'(16);
      segments_v <= SegW'(16);
    end else if (psel && penable && pwrite) begin
      case (paddr)
        AddrSegU: segments_u <= pwdata[SegW-1:0];
        AddrSegV: segments_v <= pwdata[SegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      AddrSegU: prdata = {21'd0, segments_u};
      AddrSegV: prdata = {21'd0, segments_v};
      default:  prdata = '0;
    endcase
  end

  uvs_front u_front (
    .clk(clk), .rst(rst), .start(start), .column_index(column_index),
    .row_index(row_index), .seg_u(segments_u), .seg_v(segments_v),
    .pop(q_valid), .busy(busy), .q_valid(q_valid), .q_item(q_item)
  );

  uvs_back u_back (
    .clk(clk), .rst(rst), .in_valid(q_valid), .in_item(q_item), .done(done),
    .vertex_index(vertex_index), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .tex_u(tex_u), .tex_v(tex_v), .face_valid(face_valid),
    .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
    .corner_d(corner_d)
  );

endmodule

// ===== src/uvs_checker.sv =====
`timescale 1ns / 1ps
module uvs_checker
  import uvs_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            done,
  input logic            face_valid,
  input logic [IdxW-1:0] vertex_index,
  input logic [IdxW-1:0] corner_a,
  input logic [IdxW-1:0] corner_b,
  input logic [IdxW-1:0] corner_d,
  input logic [IdxW-1:0] corner_c
);

  a_corner_a: assert property (@(posedge clk) disable iff (rst)
    done && face_valid |-> corner_a == vertex_index) else $error("corner_a");
  a_corner_b: assert property (@(posedge clk) disable iff (rst)
    done && face_valid |-> corner_b == vertex_index + 1'b1) else $error("corner_b");
  a_corner_cd: assert property (@(posedge clk) disable iff (rst)
    done && face_valid |-> corner_c == corner_d + 1'b1) else $error("corner_cd");
  a_no_face: assert property (@(posedge clk) disable iff (rst)
    done && !face_valid |-> corner_a == '0 && corner_c == '0) else $error("no face");

endmodule

bind uv_sphere_vertex_generator_core uvs_checker u_chk (
  .clk(clk), .rst(rst), .done(done), .face_valid(face_valid),
  .vertex_index(vertex_index), .corner_a(corner_a), .corner_b(corner_b),
  .corner_d(corner_d), .corner_c(corner_c)
);
